### design/ccr_pkg.sv
package ccr_pkg;

    localparam int LINES = 10;
    localparam int WIN = 11;
    localparam int RING = 16;
    localparam int DIM_MIN = 11;
    localparam int RAD = 5;

    localparam logic [1:0] CFG_WIDTH = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SUPPRESS = 2'd2;

    localparam logic signed [15:0] MIN_INIT = 16'sd32767;

    // ring sample positions inside the window, ring order
    localparam int RING_ROW [RING] = '{0, 0, 0, 1, 3, 5, 7, 9, 10, 10, 10, 9, 7, 5, 3, 1};
    localparam int RING_COL [RING] = '{7, 5, 3, 1, 0, 0, 0, 1, 3, 5, 7, 9, 10, 10, 10, 9};

    typedef logic [LINES-1:0][7:0] t_col;
    typedef logic [WIN-1:0][WIN-1:0][7:0] t_win;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic signed [15:0] response;
        logic [10:0]        center_column;
        logic [10:0]        center_row;
        logic signed [15:0] running_min;
        logic [13:0]        running_max;
        logic               last_of_frame;
    } t_out;

    typedef struct packed {
        logic        frame_start;
        logic        interior;
        logic        last;
        logic [10:0] col;
        logic [10:0] row;
    } t_tag;

endpackage

### design/chess_corner_response.sv
// ChESS corner detector, radius 5, scaled by five.
// Input channel: one grey pixel per request in raster order, frame_start on
// the first pixel of a frame. Output channel: one request per interior pixel
// (full 11x11 window inside the frame) with response, center coordinates,
// running min/max of the frame and a last_of_frame flag.
// Throughput is one pixel per clock while the receiver does not stall; the line
// store is a 10-byte-wide single memory indexed by column, read and written
// once per pixel. Pixels on the frame border flow through the pipe and give no
// output. Configuration: index 0 width, 1 height, 2 suppress_negatives; the user
// must see that it is written only while the block is idle, which the block
// itself does not enforce. Reset sets 640 x 480, suppression on, counters to
// zero and min/max to their start values; the line store is not cleared. When
// the receiver stalls, results back up through the five stages; the input is
// stalled once every stage holds a pixel.
module chess_corner_response #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ccr_pkg::t_in    i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ccr_pkg::t_out   o_out,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_addr,
    input  logic [11:0]     i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int EW0 = (DW > HW) ? DW : HW;
    localparam int EW = (EW0 > 12) ? EW0 : 12;
    localparam int WLINE = ccr_pkg::LINES;

    logic [11:0] r_width;
    logic [11:0] r_height;
    logic        r_suppress;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [3:0]    r_rsel;

    logic r_v1, r_v2, r_v3, r_v4;
    logic free1, free2, free3, free4, free_out;
    logic acc;

    ccr_pkg::t_tag r_tag1, r_tag2, r_tag3, r_tag4;
    ccr_pkg::t_tag n_tag;
    logic [7:0]    r_px1;
    logic [3:0]    r_rsel1;

    logic [EW-1:0] w_eff, h_eff, c0, r0, c1, r1;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [3:0]    rsel0, n_rsel;

    ccr_pkg::t_col col_data;
    ccr_pkg::t_win win;
    logic signed [15:0] res;

    logic signed [15:0] r_min, n_min;
    logic [13:0]        r_max, n_max;
    logic               r_ov;
    ccr_pkg::t_out      r_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 12'd640;
            r_height <= 12'd480;
            r_suppress <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ccr_pkg::CFG_WIDTH:    r_width <= i_cfg_data;
                ccr_pkg::CFG_HEIGHT:   r_height <= i_cfg_data;
                ccr_pkg::CFG_SUPPRESS: r_suppress <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (EW'(r_width) < EW'(ccr_pkg::DIM_MIN)) begin
            w_eff = EW'(ccr_pkg::DIM_MIN);
        end else if (EW'(r_width) > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(r_width);
        end
        if (EW'(r_height) < EW'(ccr_pkg::DIM_MIN)) begin
            h_eff = EW'(ccr_pkg::DIM_MIN);
        end else if (EW'(r_height) > EW'(MAX_HEIGHT)) begin
            h_eff = EW'(MAX_HEIGHT);
        end else begin
            h_eff = EW'(r_height);
        end
    end

    // stage handshake
    assign free_out = !r_ov || i_out_ready;
    assign free4 = !r_v4 || free_out;
    assign free3 = !r_v3 || free4;
    assign free2 = !r_v2 || free3;
    assign free1 = !r_v1 || free2;
    assign o_in_ready = free1;
    assign acc = i_in_valid && free1;

    // raster counters
    always_comb begin
        c0 = i_in.frame_start ? '0 : EW'(r_col);
        r0 = i_in.frame_start ? '0 : EW'(r_row);
        rsel0 = i_in.frame_start ? '0 : r_rsel;
        c1 = c0 + EW'(1);
        r1 = r0 + EW'(1);
        n_col = c1[CW-1:0];
        n_row = r0[RW-1:0];
        n_rsel = rsel0;
        if (c1 >= w_eff) begin
            n_col = '0;
            if (r1 >= h_eff) begin
                n_row = '0;
                n_rsel = '0;
            end else begin
                n_row = r1[RW-1:0];
                n_rsel = (rsel0 == 4'(WLINE - 1)) ? '0 : rsel0 + 4'd1;
            end
        end else if (r0 >= h_eff) begin
            n_row = '0;
            n_rsel = '0;
        end
        n_tag.frame_start = i_in.frame_start;
        n_tag.interior = c0 >= EW'(WLINE) && r0 >= EW'(WLINE)
                       && c0 < w_eff && r0 < h_eff;
        n_tag.last = c0 == w_eff - EW'(1) && r0 == h_eff - EW'(1);
        n_tag.col = 11'(c0 - EW'(ccr_pkg::RAD));
        n_tag.row = 11'(r0 - EW'(ccr_pkg::RAD));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_rsel <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
            r_rsel <= n_rsel;
        end
    end

    ccr_line_mem #(
        .DEPTH(MAX_WIDTH),
        .AW(CW)
    ) u_mem (
        .i_clk(i_clk),
        .i_en(acc),
        .i_addr(c0[CW-1:0]),
        .i_sel(rsel0),
        .i_px(i_in.pixel),
        .o_rdata(col_data)
    );

    ccr_window u_win (
        .i_clk(i_clk),
        .i_shift(r_v1 && free2),
        .i_col(col_data),
        .i_rsel(r_rsel1),
        .i_px(r_px1),
        .o_win(win)
    );

    ccr_calc u_calc (
        .i_clk(i_clk),
        .i_ld3(free3),
        .i_ld4(free4),
        .i_suppress(r_suppress),
        .i_win(win),
        .o_res(res)
    );

    // pipeline valids and tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (free1) r_v1 <= acc;
            if (free2) r_v2 <= r_v1;
            if (free3) r_v3 <= r_v2;
            if (free4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_tag1 <= n_tag;
            r_px1 <= i_in.pixel;
            r_rsel1 <= rsel0;
        end
        if (free2) r_tag2 <= r_tag1;
        if (free3) r_tag3 <= r_tag2;
        if (free4) r_tag4 <= r_tag3;
    end

    // running min and max
    always_comb begin
        n_min = r_tag4.frame_start ? ccr_pkg::MIN_INIT : r_min;
        n_max = r_tag4.frame_start ? '0 : r_max;
        if (r_tag4.interior) begin
            if (res > $signed({2'b00, n_max})) begin
                n_max = res[13:0];
            end else if (res < n_min) begin
                n_min = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= ccr_pkg::MIN_INIT;
            r_max <= '0;
            r_ov <= 1'b0;
        end else if (free_out) begin
            r_ov <= r_v4 && r_tag4.interior;
            if (r_v4) begin
                r_min <= n_min;
                r_max <= n_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_out && r_v4) begin
            r_out.response <= res;
            r_out.center_column <= r_tag4.col;
            r_out.center_row <= r_tag4.row;
            r_out.running_min <= n_min;
            r_out.running_max <= n_max;
            r_out.last_of_frame <= r_tag4.last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out = r_out;

`ifndef SYNTHESIS
    a_max_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $signed({2'b00, o_out.running_max}) >= o_out.response)
        else $error("running max below response");

    a_rsel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsel < 4'(WLINE))
        else $error("line select out of range");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready && r_v1 && r_v4)
        else $error("input stalled without output back-pressure");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_col) < EW'(MAX_WIDTH))
        else $error("column counter out of range");
`endif

endmodule

### design/ccr_line_mem.sv
module ccr_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW = 11
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [AW-1:0]   i_addr,
    input  logic [3:0]      i_sel,
    input  logic [7:0]      i_px,
    output ccr_pkg::t_col   o_rdata
);

    ccr_pkg::t_col r_mem [DEPTH];
    ccr_pkg::t_col r_rdata;

    // read returns the column before this request's byte lands
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata <= r_mem[i_addr];
            r_mem[i_addr][i_sel] <= i_px;
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/ccr_window.sv
module ccr_window (
    input  logic            i_clk,
    input  logic            i_shift,
    input  ccr_pkg::t_col   i_col,
    input  logic [3:0]      i_rsel,
    input  logic [7:0]      i_px,
    output ccr_pkg::t_win   o_win
);

    ccr_pkg::t_win r_win;
    ccr_pkg::t_win n_win;

    always_comb begin
        logic [4:0] idx;
        n_win = r_win;
        for (int y = 0; y < ccr_pkg::WIN; y++) begin
            for (int x = 0; x < ccr_pkg::WIN - 1; x++) begin
                n_win[y][x] = r_win[y][x+1];
            end
        end
        for (int k = 0; k < ccr_pkg::LINES; k++) begin
            idx = 5'(i_rsel) + 5'(k);
            if (idx >= 5'(ccr_pkg::LINES)) begin
                idx = idx - 5'(ccr_pkg::LINES);
            end
            n_win[k][ccr_pkg::WIN-1] = i_col[idx[3:0]];
        end
        n_win[ccr_pkg::WIN-1][ccr_pkg::WIN-1] = i_px;
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win <= n_win;
        end
    end

    assign o_win = r_win;

endmodule

### design/ccr_calc.sv
module ccr_calc (
    input  logic                i_clk,
    input  logic                i_ld3,
    input  logic                i_ld4,
    input  logic                i_suppress,
    input  ccr_pkg::t_win       i_win,
    output logic signed [15:0]  o_res
);

    logic [10:0] r_sr, n_sr;
    logic [10:0] r_dr, n_dr;
    logic [11:0] r_rs, n_rs;
    logic [10:0] r_cs, n_cs;
    logic signed [15:0] r_res, n_res;

    // ring terms, sums and cross sum
    always_comb begin
        logic [7:0] ring [ccr_pkg::RING];
        logic signed [9:0] s;
        logic signed [9:0] d0;
        logic signed [9:0] d1;
        for (int j = 0; j < ccr_pkg::RING; j++) begin
            ring[j] = i_win[ccr_pkg::RING_ROW[j]][ccr_pkg::RING_COL[j]];
        end
        n_sr = '0;
        n_dr = '0;
        n_rs = '0;
        for (int j = 0; j < 4; j++) begin
            s = $signed({2'b00, ring[j]}) - $signed({2'b00, ring[j+4]})
              + $signed({2'b00, ring[j+8]}) - $signed({2'b00, ring[j+12]});
            d0 = $signed({2'b00, ring[j]}) - $signed({2'b00, ring[j+8]});
            d1 = $signed({2'b00, ring[j+4]}) - $signed({2'b00, ring[j+12]});
            n_sr = n_sr + 11'(s < 0 ? -s : s);
            n_dr = n_dr + 11'(d0 < 0 ? -d0 : d0) + 11'(d1 < 0 ? -d1 : d1);
            n_rs = n_rs + 12'(ring[j]) + 12'(ring[j+4]) + 12'(ring[j+8])
                 + 12'(ring[j+12]);
        end
        n_cs = 11'(i_win[4][5]) + 11'(i_win[5][4]) + 11'(i_win[5][5])
             + 11'(i_win[5][6]) + 11'(i_win[6][5]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld3) begin
            r_sr <= n_sr;
            r_dr <= n_dr;
            r_rs <= n_rs;
            r_cs <= n_cs;
        end
    end

    // 5*sr - 5*dr - |5*rs - 16*cs|
    always_comb begin
        logic signed [16:0] sr5;
        logic signed [16:0] dr5;
        logic signed [16:0] t;
        logic signed [16:0] res;
        sr5 = $signed({6'd0, r_sr}) + $signed({4'd0, r_sr, 2'b00});
        dr5 = $signed({6'd0, r_dr}) + $signed({4'd0, r_dr, 2'b00});
        t = $signed({5'd0, r_rs}) + $signed({3'd0, r_rs, 2'b00})
          - $signed({2'd0, r_cs, 4'd0});
        res = sr5 - dr5 - (t < 0 ? -t : t);
        if (i_suppress && res < 0) begin
            res = '0;
        end
        n_res = res[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ld4) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int MAXW = 2048;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          o_in_ready;
    ccr_pkg::t_in  in_data = '0;
    logic          o_out_valid;
    logic          out_ready = 1'b0;
    ccr_pkg::t_out o_out;
    logic          cfg_we = 1'b0;
    logic [1:0]    cfg_addr = ccr_pkg::CFG_WIDTH;
    logic [11:0]   cfg_data = '0;

    chess_corner_response i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  line_mem [ccr_pkg::LINES][MAXW];
    logic [7:0]  win_m [ccr_pkg::WIN][ccr_pkg::WIN];
    int          col_cnt;
    int          row_cnt;
    int          run_min;
    int          run_max;
    logic [11:0] w_reg;
    logic [11:0] h_reg;
    logic        sup_reg;

    ccr_pkg::t_out resp_q [$];
    int          errors = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    int          stall_mode = 0;
    int          cyc = 0;

    function automatic int clamp_dim(input logic [11:0] v);
        if (v < ccr_pkg::DIM_MIN) return ccr_pkg::DIM_MIN;
        if (v > MAXW) return MAXW;
        return int'(v);
    endfunction

    function automatic int iabs(input int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int chess_score();
        int ring [ccr_pkg::RING];
        int sr;
        int dr;
        int rs;
        int cs;
        sr = 0;
        dr = 0;
        rs = 0;
        for (int j = 0; j < ccr_pkg::RING; j++)
            ring[j] = int'(win_m[ccr_pkg::RING_ROW[j]][ccr_pkg::RING_COL[j]]);
        cs = int'(win_m[4][5]) + int'(win_m[5][4]) + int'(win_m[5][5])
           + int'(win_m[5][6]) + int'(win_m[6][5]);
        for (int j = 0; j < 4; j++) begin
            sr += iabs(ring[j] - ring[j+4] + ring[j+8] - ring[j+12]);
            dr += iabs(ring[j] - ring[j+8]) + iabs(ring[j+4] - ring[j+12]);
            rs += ring[j] + ring[j+4] + ring[j+8] + ring[j+12];
        end
        return 5 * sr - 5 * dr - iabs(5 * rs - 16 * cs);
    endfunction

    function automatic void predict_pixel(input ccr_pkg::t_in it);
        int   w;
        int   h;
        int   c;
        int   r;
        int   res;
        ccr_pkg::t_out o;
        w = clamp_dim(w_reg);
        h = clamp_dim(h_reg);
        if (it.frame_start) begin
            col_cnt = 0;
            row_cnt = 0;
            run_min = 32767;
            run_max = 0;
        end
        c = col_cnt;
        r = row_cnt;
        for (int y = 0; y < ccr_pkg::WIN; y++)
            for (int x = 0; x < ccr_pkg::WIN - 1; x++) win_m[y][x] = win_m[y][x+1];
        for (int k = 0; k < ccr_pkg::LINES; k++)
            win_m[k][ccr_pkg::WIN-1] = line_mem[(r + k) % ccr_pkg::LINES][c % MAXW];
        win_m[ccr_pkg::WIN-1][ccr_pkg::WIN-1] = it.pixel;
        line_mem[r % ccr_pkg::LINES][c % MAXW] = it.pixel;
        if (c >= ccr_pkg::LINES && r >= ccr_pkg::LINES && c < w && r < h) begin
            res = chess_score();
            if (sup_reg && res < 0) res = 0;
            if (res > run_max) run_max = res;
            else if (res < run_min) run_min = res;
            o.response = res[15:0];
            o.center_column = 11'(c - ccr_pkg::RAD);
            o.center_row = 11'(r - ccr_pkg::RAD);
            o.running_min = run_min[15:0];
            o.running_max = run_max[13:0];
            o.last_of_frame = (c == w - 1 && r == h - 1);
            resp_q.push_back(o);
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end else if (r >= h) begin
            r = 0;
        end
        col_cnt = c;
        row_cnt = r;
    endfunction

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        ccr_pkg::t_out e;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (resp_q.size() == 0) begin
                report($sformatf("unexpected result %h", o_out));
            end else begin
                e = resp_q.pop_front();
                if (o_out.response !== e.response)
                    report($sformatf("response %0d exp %0d", o_out.response, e.response));
                if (o_out.center_column !== e.center_column)
                    report($sformatf("column %0d exp %0d", o_out.center_column,
                                     e.center_column));
                if (o_out.center_row !== e.center_row)
                    report($sformatf("row %0d exp %0d", o_out.center_row, e.center_row));
                if (o_out.running_min !== e.running_min)
                    report($sformatf("min %0d exp %0d", o_out.running_min, e.running_min));
                if (o_out.running_max !== e.running_max)
                    report($sformatf("max %0d exp %0d", o_out.running_max, e.running_max));
                if (o_out.last_of_frame !== e.last_of_frame)
                    report($sformatf("last %0b exp %0b", o_out.last_of_frame,
                                     e.last_of_frame));
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 9) > 2);
            2: out_ready <= (cyc % 5 != 0);
            default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic send_pixel(input logic [7:0] px, input logic fs);
        ccr_pkg::t_in it;
        int  gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        it.pixel = px;
        it.frame_start = fs;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_pixel(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (15) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            ccr_pkg::CFG_WIDTH: w_reg = val;
            ccr_pkg::CFG_HEIGHT: h_reg = val;
            default: sup_reg = val[0];
        endcase
    endtask

    task automatic set_geometry(input logic [11:0] w, input logic [11:0] h, input logic sup);
        drain();
        write_reg(ccr_pkg::CFG_WIDTH, w);
        write_reg(ccr_pkg::CFG_HEIGHT, h);
        write_reg(ccr_pkg::CFG_SUPPRESS, {11'd0, sup});
    endtask

    // pattern 0 random, 1 black/white noise, 2 quadrant corner, 3 checker, 4 flat
    function automatic logic [7:0] pattern_px(input int pat, input int x, input int y,
                                              input int cx, input int cy, input logic [7:0] v);
        case (pat)
            0: return 8'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            2: return ((x < cx) ^ (y < cy)) ? 8'(255 - $urandom_range(0, 20))
                                           : 8'($urandom_range(0, 20));
            3: return ((x + y) % 2) ? 8'd255 : 8'd0;
            default: return v;
        endcase
    endfunction

    // stream n pixels as a frame of width w, optional frame_start on the first
    task automatic send_frame(input int w, input int h, input int pat, input logic fs,
                              input int n, input logic [7:0] v);
        int cx;
        int cy;
        cx = $urandom_range(3, w - 3);
        cy = $urandom_range(3, h - 3);
        for (int i = 0; i < n; i++)
            send_pixel(pattern_px(pat, i % w, i / w, cx, cy, v), fs && i == 0);
    endtask

    task automatic test_reset_defaults();
        send_frame(640, 480, 0, 1'b1, 100, 8'd0);
    endtask

    task automatic test_directed();
        set_geometry(12'd11, 12'd11, 1'b0);
        send_frame(11, 11, 3, 1'b1, 121, 8'd0);
        send_frame(11, 11, 4, 1'b1, 121, 8'd255);
        send_frame(11, 11, 2, 1'b1, 121, 8'd0);
        set_geometry(12'd11, 12'd11, 1'b1);
        send_frame(11, 11, 3, 1'b1, 121, 8'd0);
        send_frame(11, 11, 1, 1'b1, 121, 8'd0);
    endtask

    task automatic test_saturation();
        set_geometry(12'd0, 12'd4095, 1'b0);
        send_frame(11, 14, 1, 1'b1, 11 * 13, 8'd0);
        set_geometry(12'd11, 12'd10, 1'b1);
        send_frame(11, 11, 0, 1'b1, 121, 8'd0);
        set_geometry(12'd4095, 12'd12, 1'b0);
        send_frame(2048, 12, 2, 1'b1, 100, 8'd0);
    endtask

    task automatic test_random_frames();
        int sent;
        int w;
        int h;
        int n;
        int pat;
        int roll;
        sent = 0;
        while (sent < 300) begin
            w = $urandom_range(11, 18);
            h = $urandom_range(11, 14);
            set_geometry(12'(w), 12'(h), 1'($urandom_range(0, 1)));
            pat = $urandom_range(0, 2);
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                n = w * h;
                send_frame(w, h, pat, 1'b1, n, 8'd0);
            end else if (roll < 8) begin
                // two frames back to back, second one starts by wrap-around
                n = 2 * w * h;
                send_frame(w, h, pat, 1'b1, w * h, 8'd0);
                send_frame(w, h, pat, 1'b0, w * h, 8'd0);
            end else if (roll < 9) begin
                n = $urandom_range(1, w * h - 1);
                send_frame(w, h, pat, 1'b1, n, 8'd0);
            end else begin
                // restart in mid-frame
                n = $urandom_range(1, w * h - 1);
                send_frame(w, h, 0, 1'b1, n, 8'd0);
                send_frame(w, h, pat, 1'b1, w * h, 8'd0);
                n += w * h;
            end
            sent += n;
        end
    endtask

    initial begin
        col_cnt = 0;
        row_cnt = 0;
        run_min = 32767;
        run_max = 0;
        w_reg = 12'd640;
        h_reg = 12'd480;
        sup_reg = 1'b1;
        for (int y = 0; y < ccr_pkg::WIN; y++)
            for (int x = 0; x < ccr_pkg::WIN; x++) win_m[y][x] = 8'd0;
        for (int k = 0; k < ccr_pkg::LINES; k++)
            for (int x = 0; x < MAXW; x++) line_mem[k][x] = 8'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed();
        test_saturation();
        test_random_frames();
        drain();
        repeat (20) @(posedge i_clk);
        if (resp_q.size() != 0) report($sformatf("%0d results never arrived", resp_q.size()));
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

endmodule
